@@ src/anxb_pkg.sv @@
// ----------------------------------------------------------------------------
// anxb_pkg
// Shared types and constants of the Annex-B NAL unit splitter.
// ----------------------------------------------------------------------------
package anxb_pkg;

  // width of the internal byte counter and offsets
  localparam int OFFSET_BITS = 24;
  // width of the offset and size fields on the result channel
  localparam int FIELD_W     = 24;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  localparam logic [2:0] CODE_SIZE_SHORT = 3'd3;
  localparam logic [2:0] CODE_SIZE_LONG  = 3'd4;

  // result queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [FIELD_W-1:0]     field_t;

  typedef enum logic [1:0] {
    KIND_UNIT         = 2'd0,
    KIND_END_OK       = 2'd1,
    KIND_END_NO_CODE  = 2'd2,
    KIND_END_TOO_LONG = 2'd3
  } result_kind_t;

  // what one input byte leaves for the back end: a unit record, an end result, or both
  typedef struct packed {
    logic         has_rec;
    field_t       code_offset;
    logic [2:0]   code_size;
    field_t       payload_offset;
    field_t       payload_size;
    logic         has_end;
    result_kind_t end_kind;
  } entry_t;

endpackage

@@ src/anxb_if.sv @@
// ----------------------------------------------------------------------------
// anxb_in_if / anxb_out_if
// Valid/ready channels for the byte stream and the result stream.
// ----------------------------------------------------------------------------
interface anxb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, data_byte, stream_end, input ready);
  modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface anxb_out_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             result_kind;
  anxb_pkg::field_t       code_offset;
  logic [2:0]             code_size;
  anxb_pkg::field_t       payload_offset;
  anxb_pkg::field_t       payload_size;
  logic                   final_result;

  modport source (output valid, result_kind, code_offset, code_size, payload_offset,
                  payload_size, final_result, input ready);
  modport sink   (input valid, result_kind, code_offset, code_size, payload_offset,
                  payload_size, final_result, output ready);
endinterface

@@ src/anxb_front.sv @@
// ----------------------------------------------------------------------------
// anxb_front
// Scans the byte stream for start codes and builds unit records and end results.
// ----------------------------------------------------------------------------
module anxb_front (
  input  logic              clk,
  input  logic              rst,
  anxb_in_if.sink           stream,
  input  logic              fifo_full,
  output logic              push,
  output anxb_pkg::entry_t  entry
);

  localparam int OB = anxb_pkg::OFFSET_BITS;

  anxb_pkg::offset_t byte_position;
  logic [7:0]        recent0, recent1, recent2;
  logic [OB:0]       scan_start;
  logic              inside_unit;
  anxb_pkg::offset_t open_code_offset;
  logic [2:0]        open_code_size;
  logic              any_unit_emitted;
  logic              overflowed;

  logic              accept;
  logic              detect;
  logic              four_byte;
  anxb_pkg::offset_t coff;
  logic [2:0]        csz;
  anxb_pkg::offset_t open_poff;
  logic [OB:0]       stop;
  logic [OB:0]       psz;
  logic              overflowed_next;
  logic              rec;
  logic              any_next;

  assign stream.ready = !fifo_full;
  assign accept       = stream.valid && stream.ready;

  always_comb begin
    detect    = !overflowed && stream.data_byte == 8'd1 && recent0 == 8'd0 &&
                recent1 == 8'd0 && byte_position >= OB'(2);
    four_byte = recent2 == 8'd0 &&
                {2'b00, byte_position} >= ({1'b0, scan_start} + (OB+2)'(3));
    coff      = four_byte ? byte_position - OB'(3) : byte_position - OB'(2);
    csz       = four_byte ? anxb_pkg::CODE_SIZE_LONG : anxb_pkg::CODE_SIZE_SHORT;
    open_poff = open_code_offset + OB'(open_code_size);
    stop      = detect ? {1'b0, coff} : ({1'b0, byte_position} + (OB+1)'(1));
    psz       = stop - {1'b0, open_poff};
    overflowed_next = overflowed || byte_position == anxb_pkg::OFFSET_MAX;
    // a start code on the final byte opens an empty unit, so one record at most
    rec       = inside_unit && !overflowed && stop > {1'b0, open_poff} &&
                (detect || (stream.stream_end && !overflowed_next));
    any_next  = any_unit_emitted || rec;
  end

  always_comb begin
    entry.has_rec        = rec;
    entry.code_offset    = anxb_pkg::FIELD_W'(open_code_offset);
    entry.code_size      = open_code_size;
    entry.payload_offset = anxb_pkg::FIELD_W'(open_poff);
    entry.payload_size   = anxb_pkg::FIELD_W'(psz);
    entry.has_end        = stream.stream_end;
    priority if (overflowed_next) begin
      entry.end_kind = anxb_pkg::KIND_END_TOO_LONG;
    end else if (!any_next) begin
      entry.end_kind = anxb_pkg::KIND_END_NO_CODE;
    end else begin
      entry.end_kind = anxb_pkg::KIND_END_OK;
    end
  end

  assign push = accept && (rec || stream.stream_end);

  always_ff @(posedge clk) begin
    if (rst || (accept && stream.stream_end)) begin
      byte_position    <= '0;
      recent0          <= '1;
      recent1          <= '1;
      recent2          <= '1;
      scan_start       <= '0;
      inside_unit      <= 1'b0;
      open_code_offset <= '0;
      open_code_size   <= '0;
      any_unit_emitted <= 1'b0;
      overflowed       <= 1'b0;
    end else if (accept) begin
      any_unit_emitted <= any_next;
      if (!overflowed) begin
        if (detect) begin
          inside_unit      <= 1'b1;
          open_code_offset <= coff;
          open_code_size   <= csz;
          scan_start       <= {1'b0, byte_position} + (OB+1)'(1);
        end
        recent2 <= recent1;
        recent1 <= recent0;
        recent0 <= stream.data_byte;
        if (byte_position == anxb_pkg::OFFSET_MAX) begin
          overflowed <= 1'b1;
        end else begin
          byte_position <= byte_position + OB'(1);
        end
      end
    end
  end

endmodule

@@ src/anxb_fifo.sv @@
// ----------------------------------------------------------------------------
// anxb_fifo
// Short queue of result entries between the scanner and the output stage.
// ----------------------------------------------------------------------------
module anxb_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  anxb_pkg::entry_t  push_entry,
  input  logic              pop,
  output anxb_pkg::entry_t  head,
  output logic              full,
  output logic              empty
);

  localparam int AW = anxb_pkg::FIFO_AW;

  anxb_pkg::entry_t mem [anxb_pkg::FIFO_DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign full  = count == (AW+1)'(anxb_pkg::FIFO_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/anxb_back.sv @@
// ----------------------------------------------------------------------------
// anxb_back
// Turns queued entries into result items, the unit record before the end result.
// ----------------------------------------------------------------------------
module anxb_back (
  input  logic              clk,
  input  logic              rst,
  input  anxb_pkg::entry_t  head,
  input  logic              empty,
  output logic              pop,
  anxb_out_if.source        result
);

  logic phase;          // record of the head entry already delivered
  logic show_rec;
  logic take;

  assign show_rec = head.has_rec && !phase;
  assign take     = result.valid && result.ready;
  assign pop      = take && !(show_rec && head.has_end);

  always_comb begin
    result.valid = !empty;
    if (show_rec) begin
      result.result_kind    = anxb_pkg::KIND_UNIT;
      result.code_offset    = head.code_offset;
      result.code_size      = head.code_size;
      result.payload_offset = head.payload_offset;
      result.payload_size   = head.payload_size;
      result.final_result   = 1'b0;
    end else begin
      result.result_kind    = head.end_kind;
      result.code_offset    = '0;
      result.code_size      = '0;
      result.payload_offset = '0;
      result.payload_size   = '0;
      result.final_result   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (take) begin
      phase <= show_rec && head.has_end;
    end
  end

endmodule

@@ src/annexb_nal_unit_splitter.sv @@
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an Annex-B byte stream into NAL unit records.
// ----------------------------------------------------------------------------
// Usage:
//   stream : one byte per item, stream_end high on the final byte.
//   result : unit records (kind 0: start code offset/size, payload offset/size),
//            and after the final byte an end result with final_result high
//            (kind 1 ok, 2 no start code found, 3 stream longer than the
//            offset range).
//   One byte is taken every cycle while the queue is not full. A record is
//   queued as the byte that closes its unit is taken and offered on result
//   from there; the final byte may give two items, the record first.
//   The scanner and the output stage are parted by a four-entry queue; when
//   the receiver stalls the queue fills and stream.ready drops once it is
//   full. Bytes that produce no result never occupy the queue.
//   Reset (rst, synchronous) clears the scan state and empties the queue.
//   After the end result's byte is taken the scanner returns to its reset
//   state by itself, so the next stream may follow at once.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter (
  input  logic        clk,
  input  logic        rst,
  anxb_in_if.sink     stream,
  anxb_out_if.source  result
);

  anxb_pkg::entry_t push_entry;
  anxb_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  anxb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream),
    .fifo_full (full),
    .push      (push),
    .entry     (push_entry)
  );

  anxb_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  anxb_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

@@ tb/sv/annexb_nal_unit_splitter_checker.sv @@
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_checker
// Watches the byte and result channels of the Annex-B splitter, runs its own
// start code scanner on every accepted byte and compares each accepted result
// item, field by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter_checker (
  input  logic clk,
  input  logic rst,
  anxb_in_if   stream,
  anxb_out_if  result,
  output int   fails,
  output int   pending,
  output int   checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    anxb_pkg::result_kind_t kind;
    anxb_pkg::field_t       code_offset;
    logic [2:0]             code_size;
    anxb_pkg::field_t       payload_offset;
    anxb_pkg::field_t       payload_size;
    logic                   final_result;
  } nal_result_t;

  nal_result_t expected_results[$];
  nal_result_t oldest;

  // scanner state
  longint unsigned byte_pos;
  longint unsigned scan_from;
  longint unsigned unit_start;
  logic [2:0]      unit_code_len;
  logic [7:0]      last_bytes [3];
  bit              in_unit;
  bit              unit_seen;
  bit              too_long;

  task automatic clear_scan();
    byte_pos      = 0;
    scan_from     = 0;
    unit_start    = 0;
    unit_code_len = '0;
    last_bytes    = '{8'hFF, 8'hFF, 8'hFF};
    in_unit       = 1'b0;
    unit_seen     = 1'b0;
    too_long      = 1'b0;
  endtask

  task automatic push_result(input anxb_pkg::result_kind_t kind,
                             input longint unsigned coff,
                             input logic [2:0] csize, input longint unsigned poff,
                             input longint unsigned psize, input logic fin);
    nal_result_t r;
    r.kind           = kind;
    r.code_offset    = anxb_pkg::field_t'(coff);
    r.code_size      = csize;
    r.payload_offset = anxb_pkg::field_t'(poff);
    r.payload_size   = anxb_pkg::field_t'(psize);
    r.final_result   = fin;
    expected_results.push_back(r);
  endtask

  // close the open unit at 'stop' (exclusive); empty payloads give nothing
  task automatic close_open_unit(input longint unsigned stop);
    longint unsigned body;
    body = (unit_start + unit_code_len) & longint'(anxb_pkg::OFFSET_MAX);
    if (in_unit && stop > body) begin
      push_result(anxb_pkg::KIND_UNIT, unit_start, unit_code_len, body, stop - body,
                  1'b0);
      unit_seen = 1'b1;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    longint unsigned        at;
    longint unsigned        code_at;
    logic [2:0]             code_len;
    anxb_pkg::result_kind_t end_kind;
    at = byte_pos;
    if (!too_long) begin
      if (b == 8'h01 && last_bytes[0] == 8'h00 && last_bytes[1] == 8'h00 && at >= 2) begin
        // long form only when the extra zero lies inside the current scan window
        if (last_bytes[2] == 8'h00 && at >= scan_from + 3) begin
          code_at  = at - 3;
          code_len = anxb_pkg::CODE_SIZE_LONG;
        end else begin
          code_at  = at - 2;
          code_len = anxb_pkg::CODE_SIZE_SHORT;
        end
        close_open_unit(code_at);
        in_unit       = 1'b1;
        unit_start    = code_at;
        unit_code_len = code_len;
        scan_from     = at + 1;
      end
      last_bytes[2] = last_bytes[1];
      last_bytes[1] = last_bytes[0];
      last_bytes[0] = b;
      if (at >= longint'(anxb_pkg::OFFSET_MAX)) too_long = 1'b1;
      else byte_pos = at + 1;
    end
    if (last) begin
      if (!too_long) close_open_unit(at + 1);
      if (too_long) end_kind = anxb_pkg::KIND_END_TOO_LONG;
      else if (!unit_seen) end_kind = anxb_pkg::KIND_END_NO_CODE;
      else end_kind = anxb_pkg::KIND_END_OK;
      push_result(end_kind, 0, '0, 0, 0, 1'b1);
      clear_scan();
    end
  endtask

  function automatic int field_diff(input string name, input longint unsigned want,
                                    input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      expected_results.delete();
    end else begin
      if (stream.valid && stream.ready) predict_byte(stream.data_byte, stream.stream_end);
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no prediction outstanding (kind %0d)",
                 result.result_kind);
          fails++;
        end else begin
          oldest = expected_results.pop_front();
          fails += field_diff("result_kind", oldest.kind, result.result_kind);
          fails += field_diff("code_offset", oldest.code_offset, result.code_offset);
          fails += field_diff("code_size", oldest.code_size, result.code_size);
          fails += field_diff("payload_offset", oldest.payload_offset,
                              result.payload_offset);
          fails += field_diff("payload_size", oldest.payload_size, result.payload_size);
          fails += field_diff("final_result", oldest.final_result, result.final_result);
          checked++;
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ tb/sv/annexb_nal_unit_splitter_test.sv @@
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_test
// Drives directed and random Annex-B byte streams into the splitter with bursty
// input and a stalling receiver, including one long hold-off that backs the
// result queue up; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_THIRD} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int fail_count;
  int pending_count;
  int checked_count;
  int bytes_sent   = 0;
  int streams_sent = 0;
  int burst_left   = 0;

  logic [7:0] stream_buf[$];

  anxb_in_if  stream ();
  anxb_out_if result ();

  annexb_nal_unit_splitter i_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .result (result)
  );

  annexb_nal_unit_splitter_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream),
    .result  (result),
    .fails   (fail_count),
    .pending (pending_count),
    .checked (checked_count)
  );

  always #10 clk = ~clk;

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        stream.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    stream.valid      = 1'b1;
    stream.data_byte  = b;
    stream.stream_end = last;
    do @(posedge clk); while (!stream.ready);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_stream();
    foreach (stream_buf[i]) send_byte(stream_buf[i], i == stream_buf.size() - 1);
    streams_sent++;
  endtask

  // optional junk, then units of 3- or 4-byte start code and payload (maybe empty)
  task automatic build_well_formed();
    int units;
    int len;
    stream_buf.delete();
    repeat ($urandom_range(0, 3)) stream_buf.push_back(8'($urandom_range(0, 255)));
    units = $urandom_range(1, 4);
    for (int u = 0; u < units; u++) begin
      if ($urandom_range(0, 1)) stream_buf.push_back(8'h00);
      stream_buf.push_back(8'h00);
      stream_buf.push_back(8'h00);
      stream_buf.push_back(8'h01);
      len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
      repeat (len)
        stream_buf.push_back(($urandom_range(0, 3) == 0) ? 8'h00 :
                             8'($urandom_range(1, 255)));
    end
  endtask

  // zero-heavy noise, so partial and overlapping start codes turn up
  task automatic build_noise();
    int len;
    int pick;
    stream_buf.delete();
    len = $urandom_range(1, 30);
    repeat (len) begin
      pick = $urandom_range(0, 5);
      if (pick <= 2) stream_buf.push_back(8'h00);
      else if (pick == 3) stream_buf.push_back(8'h01);
      else stream_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // receiver: stretches of open, random or one-in-three ready, one long hold
  initial begin
    int       cyc;
    int       stretch;
    bit       held;
    rx_mode_t mode;
    cyc  = 0;
    held = 1'b0;
    result.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && cyc >= 300) begin
        held = 1'b1;
        result.ready = 1'b0;
        repeat (150) @(negedge clk);
        cyc += 150;
      end
      stretch = $urandom_range(10, 60);
      mode    = rx_mode_t'($urandom_range(0, 2));
      for (int k = 0; k < stretch; k++) begin
        case (mode)
          RX_OPEN:   result.ready = 1'b1;
          RX_RANDOM: result.ready = 1'($urandom_range(0, 1));
          default:   result.ready = (k % 3 == 0);
        endcase
        @(negedge clk);
        cyc++;
      end
    end
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    stream.valid      = 1'b0;
    stream.data_byte  = 8'h00;
    stream.stream_end = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no start code at all
    stream_buf = '{8'hFF, 8'h00};
    send_stream();
    // long code, then a short one on the final byte (empty last unit)
    stream_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h26, 8'h01, 8'h00, 8'h00, 8'h01};
    send_stream();
    // empty unit between two codes, one-byte payloads, long code mid-stream
    stream_buf = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h80,
                   8'h00, 8'h00, 8'h00, 8'h01, 8'h7F};
    send_stream();
    // single-byte stream
    stream_buf = '{8'h01};
    send_stream();

    while (bytes_sent < 530) begin
      if ($urandom_range(0, 4) != 0) build_well_formed();
      else build_noise();
      send_stream();
    end

    stream.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Streamed %0d bytes in %0d bitstreams; %0d result items compared.",
             bytes_sent, streams_sent, checked_count);
    $display("Covered short/long/empty units, codes on the final byte and a backed-up queue.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/anxb_pkg.sv
src/anxb_if.sv
src/anxb_front.sv
src/anxb_fifo.sv
src/anxb_back.sv
src/annexb_nal_unit_splitter.sv
tb/sv/annexb_nal_unit_splitter_checker.sv
tb/sv/annexb_nal_unit_splitter_test.sv
